// ===== rtl/sitoa_pkg.sv =====
package sitoa_pkg;

	localparam int CHAR_WIDTH          = 6;
	localparam int DEFAULT_VALUE_WIDTH = 32;
	localparam int QUEUE_DEPTH         = 2;

	localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO  = CHAR_WIDTH'(48);
	localparam logic [CHAR_WIDTH-1:0] ASCII_MINUS = CHAR_WIDTH'(45);

	// Decimal digits needed for a magnitude of up to 2^(w-1).
	function automatic int num_digits(input int w);
		return ((w - 1) * 30103) / 100000 + 1;
	endfunction

endpackage

// ===== rtl/signed_int_to_decimal_ascii_top.sv =====
// Converts a signed two's-complement integer into its decimal text in ASCII.
// The input channel takes one item, value, per handshake on in_valid/in_ready.
// The output channel gives one character per handshake on out_valid/out_ready,
// most significant first, with a leading '-' for negative values and no
// leading zeros; zero gives the single character '0'. The final character of
// each number has last set, and no terminator follows.
// Accepted items are registered in the front end and wait in a two-entry queue,
// so up to three numbers can be taken while the back end is still converting.
// The back end converts one number at a time: it fetches it from the queue,
// converts the VALUE_WIDTH magnitude bits to BCD by shift-and-add-3, emits the
// sign when negative, and steps through every decimal digit position, leading
// zeros included.
// When the receiver holds out_ready low, the output register keeps its
// character and the back end waits; the front keeps accepting until the queue
// fills. Reset empties the queue and the output register and idles the back end.
module signed_int_to_decimal_ascii_top import sitoa_pkg::*; #(
	parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic        [CHAR_WIDTH-1:0]  character,
	output logic                          last
);

	logic                   push_valid;
	logic                   push_ready;
	logic                   push_neg;
	logic [VALUE_WIDTH-1:0] push_mag;
	logic                   pop_valid;
	logic                   pop_ready;
	logic [VALUE_WIDTH:0]   pop_data;

	sitoa_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.value     (value),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_neg  (push_neg),
		.push_mag  (push_mag)
	);

	sitoa_queue #(
		.DATA_WIDTH(VALUE_WIDTH + 1)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(push_valid),
		.wr_ready(push_ready),
		.wr_data ({push_neg, push_mag}),
		.rd_valid(pop_valid),
		.rd_ready(pop_ready),
		.rd_data (pop_data)
	);

	sitoa_back #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_neg  (pop_data[VALUE_WIDTH]),
		.pop_mag  (pop_data[VALUE_WIDTH-1:0]),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.character(character),
		.last     (last)
	);

endmodule

// ===== rtl/sitoa_front.sv =====
module sitoa_front import sitoa_pkg::*; #(
	parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [VALUE_WIDTH-1:0] value,
	output logic                          push_valid,
	input  logic                          push_ready,
	output logic                          push_neg,
	output logic        [VALUE_WIDTH-1:0] push_mag
);

	logic                   valid_s1;
	logic                   neg_s1;
	logic [VALUE_WIDTH-1:0] mag_s1;
	logic [VALUE_WIDTH-1:0] raw;
	logic [VALUE_WIDTH-1:0] mag;

	// The magnitude is taken as unsigned, so the most negative value needs no special case.
	assign raw = value;
	assign mag = raw[VALUE_WIDTH-1] ? ((~raw) + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : raw;

	assign in_ready   = !valid_s1 || push_ready;
	assign push_valid = valid_s1;
	assign push_neg   = neg_s1;
	assign push_mag   = mag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			neg_s1 <= raw[VALUE_WIDTH-1];
			mag_s1 <= mag;
		end
	end

endmodule

// ===== rtl/sitoa_queue.sv =====
module sitoa_queue import sitoa_pkg::*; #(
	parameter int DATA_WIDTH = DEFAULT_VALUE_WIDTH + 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_valid,
	output logic                  wr_ready,
	input  logic [DATA_WIDTH-1:0] wr_data,
	output logic                  rd_valid,
	input  logic                  rd_ready,
	output logic [DATA_WIDTH-1:0] rd_data
);

	localparam int DEPTH = QUEUE_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(DEPTH + 1);

	logic [DATA_WIDTH-1:0] entry_q [DEPTH];
	logic [PW-1:0]         wr_ptr_q;
	logic [PW-1:0]         rd_ptr_q;
	logic [CW-1:0]         count_q;
	logic                  do_wr;
	logic                  do_rd;

	assign wr_ready = (count_q != CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = entry_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== rtl/sitoa_back.sv =====
module sitoa_back import sitoa_pkg::*; #(
	parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   pop_valid,
	output logic                   pop_ready,
	input  logic                   pop_neg,
	input  logic [VALUE_WIDTH-1:0] pop_mag,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [CHAR_WIDTH-1:0]  character,
	output logic                   last
);

	localparam int NDIG = num_digits(VALUE_WIDTH);
	localparam int BW   = 4 * NDIG;
	localparam int BCW  = $clog2(VALUE_WIDTH);
	localparam int DCW  = $clog2(NDIG);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_DIGITS
	} state_t;

	state_t                 state_q;
	logic [VALUE_WIDTH-1:0] mag_q;
	logic [BW-1:0]          bcd_q;
	logic [BW-1:0]          bcd_adj;
	logic [BCW-1:0]         bit_cnt_q;
	logic [DCW-1:0]         dig_cnt_q;
	logic                   neg_q;
	logic                   started_q;
	logic                   out_valid_q;
	logic [CHAR_WIDTH-1:0]  character_q;
	logic                   last_q;
	logic                   out_free;
	logic [3:0]             top_digit;
	logic                   skip_zero;
	logic                   load_out;

	// Each BCD digit of five or more is corrected by three before the next shift.
	always_comb begin
		logic [3:0] dig;
		dig = '0;
		for (int i = 0; i < NDIG; i++) begin
			dig = bcd_q[4*i +: 4];
			bcd_adj[4*i +: 4] = (dig >= 4'd5) ? (dig + 4'd3) : dig;
		end
	end

	assign out_free  = !out_valid_q || out_ready;
	assign top_digit = bcd_q[BW-1 -: 4];
	assign skip_zero = !started_q && (top_digit == 4'd0) && (dig_cnt_q != '0);
	assign load_out  = out_free && ((state_q == ST_SIGN)
		|| ((state_q == ST_DIGITS) && !skip_zero));
	assign pop_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign character = character_q;
	assign last      = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mag_q       <= '0;
			bcd_q       <= '0;
			bit_cnt_q   <= '0;
			dig_cnt_q   <= '0;
			neg_q       <= 1'b0;
			started_q   <= 1'b0;
			out_valid_q <= 1'b0;
			character_q <= '0;
			last_q      <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop_valid) begin
						mag_q     <= pop_mag;
						neg_q     <= pop_neg;
						bcd_q     <= '0;
						bit_cnt_q <= BCW'(VALUE_WIDTH - 1);
						state_q   <= ST_CONV;
					end
				end
				ST_CONV: begin
					bcd_q     <= {bcd_adj[BW-2:0], mag_q[VALUE_WIDTH-1]};
					mag_q     <= {mag_q[VALUE_WIDTH-2:0], 1'b0};
					bit_cnt_q <= bit_cnt_q - 1'b1;
					if (bit_cnt_q == '0) begin
						dig_cnt_q <= DCW'(NDIG - 1);
						started_q <= 1'b0;
						state_q   <= neg_q ? ST_SIGN : ST_DIGITS;
					end
				end
				ST_SIGN: begin
					if (out_free) begin
						character_q <= ASCII_MINUS;
						last_q      <= 1'b0;
						state_q     <= ST_DIGITS;
					end
				end
				ST_DIGITS: begin
					if (skip_zero) begin
						bcd_q     <= {bcd_q[BW-5:0], 4'd0};
						dig_cnt_q <= dig_cnt_q - 1'b1;
					end else if (out_free) begin
						character_q <= ASCII_ZERO + {{(CHAR_WIDTH-4){1'b0}}, top_digit};
						last_q      <= (dig_cnt_q == '0);
						started_q   <= 1'b1;
						bcd_q       <= {bcd_q[BW-5:0], 4'd0};
						if (dig_cnt_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							dig_cnt_q <= dig_cnt_q - 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/sitoa_checker.sv =====
module sitoa_checker import sitoa_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [CHAR_WIDTH-1:0] character,
	input logic                  last
);

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("Output item dropped while stalled.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(character) && $stable(last))
		else $error("Output item changed while stalled.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (character == ASCII_MINUS)
			|| ((character >= ASCII_ZERO) && (character <= ASCII_ZERO + CHAR_WIDTH'(9))))
		else $error("Output character is neither a minus sign nor a digit.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (character == ASCII_MINUS) |-> !last)
		else $error("A minus sign ended a number.");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && (character == ASCII_MINUS)
			|=> !(out_valid && (character == ASCII_MINUS)))
		else $error("Two minus signs in a row.");

endmodule

bind signed_int_to_decimal_ascii_top sitoa_checker u_sitoa_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.character(character),
	.last     (last)
);
